[rtl/core/rpnse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpnse_pkg
// Shared types, codes and constants of the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rpnse_pkg;

   localparam int OPCODE_WIDTH    = 3;
   localparam int NUMBER_WIDTH    = 32;
   localparam int STATUS_WIDTH    = 3;
   localparam int VALUE_WIDTH     = 32;

   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_WORD_WIDTH  = 32;

   // Largest accepted push is one below this.
   localparam int PUSH_LIMIT      = 10;
   localparam int OPERANDS_NEEDED = 2;
   localparam int FINAL_DEPTH     = 1;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_PUSH   = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_BAD    = 3'd5,
      OP_FINISH = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_BAD_TOKEN = 3'd3,
      ST_DIV_ZERO  = 3'd4,
      ST_BAD_DEPTH = 3'd5,
      ST_OVERFLOW  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD_B,
      S_RD_A,
      S_ITER,
      S_FIN_RD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } arith_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

endpackage
`default_nettype wire

[rtl/core/rpnse_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpnse_req_if
// Token channel: one classified token per transfer.
// ----------------------------------------------------------------------------
interface rpnse_req_if import rpnse_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic        [OPCODE_WIDTH-1:0] opcode;
   logic signed [NUMBER_WIDTH-1:0] number;

   modport source (output valid, output opcode, output number, input ready);
   modport sink   (input valid, input opcode, input number, output ready);
endinterface
`default_nettype wire

[rtl/core/rpnse_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpnse_rsp_if
// Result channel: one status word per token.
// ----------------------------------------------------------------------------
interface rpnse_rsp_if import rpnse_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic        [STATUS_WIDTH-1:0] status;
   logic signed [VALUE_WIDTH-1:0]  value;
   logic                           done_res;

   modport source (output valid, output status, output value, output done_res,
                   input ready);
   modport sink   (input valid, input status, input value, input done_res,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/rpnse_arith_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpnse_arith_unit
// Shared one-bit-per-cycle unit: shift-add multiply and restoring signed
// divide (truncating toward zero), WORD_WIDTH steps per operation.
// ----------------------------------------------------------------------------
module rpnse_arith_unit import rpnse_pkg::*; #(
   parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire arith_ctl_type         ctl,
   input  wire logic [WORD_WIDTH-1:0] a,
   input  wire logic [WORD_WIDTH-1:0] b,
   output      arith_sts_type         sts,
   output      logic [WORD_WIDTH-1:0] result
);

   localparam int CW = $clog2(WORD_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  div_ff, div_in;
   logic                  neg_ff, neg_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;  // product / remainder
   logic [WORD_WIDTH-1:0] x_ff, x_in;      // multiplicand / dividend-quotient
   logic [WORD_WIDTH-1:0] y_ff, y_in;      // multiplier / divisor

   logic [WORD_WIDTH:0]   rem_sh;
   logic [WORD_WIDTH:0]   rem_sub;
   logic                  rem_ge;

   always_comb begin
      rem_sh  = {acc_ff, x_ff[WORD_WIDTH-1]};
      rem_sub = rem_sh - {1'b0, y_ff};
      rem_ge  = (rem_sh >= {1'b0, y_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WORD_WIDTH);
         div_in  = ctl.is_div;
         acc_in  = '0;
         if (ctl.is_div) begin
            neg_in = a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
            x_in   = a[WORD_WIDTH-1] ? (~a + 1'b1) : a;
            y_in   = b[WORD_WIDTH-1] ? (~b + 1'b1) : b;
         end else begin
            neg_in = 1'b0;
            x_in   = a;
            y_in   = b;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (div_ff) begin
            acc_in = rem_ge ? rem_sub[WORD_WIDTH-1:0] : rem_sh[WORD_WIDTH-1:0];
            x_in   = {x_ff[WORD_WIDTH-2:0], rem_ge};
         end else begin
            // add the shifted multiplicand where the multiplier bit is set
            acc_in = y_ff[0] ? (acc_ff + x_ff) : acc_ff;
            x_in   = {x_ff[WORD_WIDTH-2:0], 1'b0};
            y_in   = {1'b0, y_ff[WORD_WIDTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   always_comb begin
      sts.busy = busy_ff;
      sts.done = done_ff;
      if (div_ff) begin
         result = neg_ff ? (~x_ff + 1'b1) : x_ff;
      end else begin
         result = acc_ff;
      end
   end

endmodule
`default_nettype wire

[rtl/core/rpn_stack_evaluator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_unit
// Reverse Polish evaluator over a single-port-read synchronous operand stack.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transfer carries
//  --------  ---------  -------------------------------------------------
//  req_chan  in         opcode (3b), number (32b signed) - one token
//  rsp_chan  out        status (3b), value (32b signed), done_res (1b)
//
//  Path per token through the states: push, bad token, a token that meets a
//  held error, an operator short of operands and a finish that reports an
//  error go from S_DECODE straight to S_DONE; a finish that reads the lone
//  value passes S_FIN_RD; add, subtract and a divide by zero pass S_RD_B and
//  S_RD_A, which read two stack entries through the one read port; multiply
//  and divide pass them too, then wait in S_ITER on the one-bit-per-cycle arithmetic unit.
//  Reset clears depth, error status and the handshake; stack contents stay
//  undefined and are never read before being written, so no clearing pass.
//  A result waits in the output register; a new token is taken while it
//  waits, and only the next result load stalls on rsp_chan.ready.
//
module rpn_stack_evaluator_unit import rpnse_pkg::*; #(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   rpnse_req_if.sink    req_chan,
   rpnse_rsp_if.source  rsp_chan
);

   localparam int DW = $clog2(STACK_DEPTH + 1);  // depth counter
   localparam int AW = $clog2(STACK_DEPTH);      // stack address

   // Control state
   state_type                    state_ff, state_in;
   logic [DW-1:0]                depth_ff, depth_in;
   status_type                   err_ff, err_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Token and result payload
   logic [OPCODE_WIDTH-1:0]      op_ff, op_in;
   logic signed [NUMBER_WIDTH-1:0] num_ff, num_in;
   logic [WORD_WIDTH-1:0]        opb_ff, opb_in;
   status_type                   pst_ff, pst_in;
   logic signed [VALUE_WIDTH-1:0] pval_ff, pval_in;
   status_type                   rsp_status_ff, rsp_status_in;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_done_ff, rsp_done_in;

   // Operand stack
   logic [WORD_WIDTH-1:0]        stack_mem [STACK_DEPTH];
   logic signed [WORD_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]                rd_addr;
   logic [AW-1:0]                wr_addr;
   logic [WORD_WIDTH-1:0]        wr_data;
   logic                         mem_we;

   // Arithmetic unit
   arith_ctl_type                arith_ctl;
   arith_sts_type                arith_sts;
   logic [WORD_WIDTH-1:0]        arith_res;

   logic                         req_xfer;
   logic                         load_rsp;
   logic [DW-1:0]                depth_m1;
   logic [DW-1:0]                depth_m2;

   rpnse_arith_unit #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arith_ctl),
      .a      (rd_data_ff),
      .b      (opb_ff),
      .sts    (arith_sts),
      .result (arith_res)
   );

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign req_xfer          = req_chan.valid && req_chan.ready;
   assign load_rsp          = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign depth_m1          = depth_ff - DW'(FINAL_DEPTH);
   assign depth_m2          = depth_ff - DW'(OPERANDS_NEEDED);

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.value    = rsp_value_ff;
   assign rsp_chan.done_res = rsp_done_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (op_ff == OP_FINISH) begin
               if (err_ff == ST_OK && depth_ff == DW'(FINAL_DEPTH)) begin
                  state_in = S_FIN_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else if (err_ff == ST_OK && op_ff inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}
                         && depth_ff >= DW'(OPERANDS_NEEDED)) begin
               state_in = S_RD_B;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RD_B: begin
            state_in = S_RD_A;
         end
         S_RD_A: begin
            if (op_ff == OP_MUL || (op_ff == OP_DIV && opb_ff != '0)) begin
               state_in = S_ITER;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ITER: begin
            if (arith_sts.done) begin
               state_in = S_DONE;
            end
         end
         S_FIN_RD: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath, stack access and result
   always_comb begin
      op_in         = op_ff;
      num_in        = num_ff;
      depth_in      = depth_ff;
      err_in        = err_ff;
      opb_in        = opb_ff;
      pst_in        = pst_ff;
      pval_in       = pval_ff;
      rd_addr       = depth_m1[AW-1:0];
      wr_addr       = depth_m2[AW-1:0];
      wr_data       = '0;
      mem_we        = 1'b0;
      arith_ctl     = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_done_in   = rsp_done_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in  = req_chan.opcode;
               num_in = req_chan.number;
            end
         end
         S_DECODE: begin
            // top entry read issued here: b for an operator, stack[0] on finish
            pval_in = '0;
            if (op_ff == OP_FINISH) begin
               if (err_ff != ST_OK) begin
                  pst_in = err_ff;
               end else if (depth_ff != DW'(FINAL_DEPTH)) begin
                  pst_in = ST_BAD_DEPTH;
               end else begin
                  pst_in = ST_OK;
               end
               depth_in = '0;
               err_in   = ST_OK;
            end else begin
               if (err_ff == ST_OK) begin
                  case (op_ff)
                     OP_PUSH: begin
                        if (!num_ff[NUMBER_WIDTH-1]
                            && num_ff >= NUMBER_WIDTH'(PUSH_LIMIT)) begin
                           err_in = ST_TOO_LARGE;
                        end else if (depth_ff == DW'(STACK_DEPTH)) begin
                           err_in = ST_OVERFLOW;
                        end else begin
                           mem_we   = 1'b1;
                           wr_addr  = depth_ff[AW-1:0];
                           wr_data  = WORD_WIDTH'(num_ff);
                           depth_in = depth_ff + 1'b1;
                        end
                     end
                     OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (depth_ff < DW'(OPERANDS_NEEDED)) begin
                           err_in = ST_UNDERFLOW;
                        end
                     end
                     default: begin
                        err_in = ST_BAD_TOKEN;
                     end
                  endcase
               end
               pst_in = err_in;
            end
         end
         S_RD_B: begin
            // hold b, fetch a
            opb_in  = rd_data_ff;
            rd_addr = depth_m2[AW-1:0];
         end
         S_RD_A: begin
            case (op_ff)
               OP_ADD: begin
                  mem_we   = 1'b1;
                  wr_data  = rd_data_ff + opb_ff;
                  depth_in = depth_m1;
               end
               OP_SUB: begin
                  mem_we   = 1'b1;
                  wr_data  = rd_data_ff - opb_ff;
                  depth_in = depth_m1;
               end
               OP_MUL: begin
                  arith_ctl.start  = 1'b1;
                  arith_ctl.is_div = 1'b0;
               end
               default: begin
                  // divide: a zero divisor drops both operands
                  if (opb_ff == '0) begin
                     err_in   = ST_DIV_ZERO;
                     depth_in = depth_m2;
                  end else begin
                     arith_ctl.start  = 1'b1;
                     arith_ctl.is_div = 1'b1;
                  end
               end
            endcase
            pst_in = err_in;
         end
         S_ITER: begin
            if (arith_sts.done) begin
               mem_we   = 1'b1;
               wr_data  = arith_res;
               depth_in = depth_m1;
            end
         end
         S_FIN_RD: begin
            pval_in = VALUE_WIDTH'(rd_data_ff);
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pst_ff;
               rsp_value_in  = pval_ff;
               rsp_done_in   = (op_ff == OP_FINISH);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      num_ff        <= num_in;
      opb_ff        <= opb_in;
      pst_ff        <= pst_in;
      pval_ff       <= pval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_done_ff   <= rsp_done_in;
   end

   // Operand stack: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_no_write_on_error : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> err_ff == ST_OK)
      else $error("stack written while an error is held");

   a_arith_done_in_iter : assert property (@(posedge clock) disable iff (reset)
      (arith_sts.busy || arith_sts.done) |-> state_ff == S_ITER)
      else $error("arithmetic unit active outside the wait state");

   a_finish_clears : assert property (@(posedge clock) disable iff (reset)
      (load_rsp && op_ff == OP_FINISH) |=> depth_ff == '0 && err_ff == ST_OK)
      else $error("finish left stack or error status behind");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rpn_stack_evaluator_unit.
// Drives classified tokens through a valid/ready channel in random bursts,
// predicts every result with a bench-side stack evaluator, and compares the
// status, value and finish flag of each result as it arrives. A short
// directed sequence opens the run; random expressions, corrupted expressions,
// stack fills and raw noise follow.
// ----------------------------------------------------------------------------
module tb import rpnse_pkg::*; ();

   // Opcode 7 has no name in the package; the block must treat it as a bad token.
   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED = 3'd7;

   localparam int OPERAND_SLOTS = DEF_STACK_DEPTH;
   localparam int RANDOM_TOKENS = 750;
   // Worst quiet stretch: a multiply or divide, a receiver stall and a sender
   // gap, taken many times over.
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic [NUMBER_WIDTH-1:0] number;
      bit                      drain_first;
   } token_type;

   typedef struct packed {
      status_type             status;
      logic [VALUE_WIDTH-1:0] value;
      logic                   done;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpnse_req_if token_bus ();
   rpnse_rsp_if result_bus ();

   rpn_stack_evaluator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (token_bus.sink),
      .rsp_chan (result_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Bench-side evaluator: its own operand stack, depth and sticky status.
   // -------------------------------------------------------------------------
   logic [VALUE_WIDTH-1:0] stack_words [OPERAND_SLOTS];
   int unsigned            stack_level = 0;
   status_type             held_status = ST_OK;

   function automatic outcome_type evaluate_token(logic [OPCODE_WIDTH-1:0] op,
                                                  logic [NUMBER_WIDTH-1:0] num);
      outcome_type            res;
      logic [VALUE_WIDTH-1:0] lhs;
      logic [VALUE_WIDTH-1:0] rhs;
      logic [VALUE_WIDTH-1:0] mag_l;
      logic [VALUE_WIDTH-1:0] mag_r;
      logic [VALUE_WIDTH-1:0] word;
      res.value = '0;
      res.done  = 1'b0;
      if (op == OP_FINISH) begin
         // Report the lone survivor, or why there is none, then start afresh.
         res.done = 1'b1;
         if (held_status != ST_OK) begin
            res.status = held_status;
         end else if (stack_level != FINAL_DEPTH) begin
            res.status = ST_BAD_DEPTH;
         end else begin
            res.status = ST_OK;
            res.value  = stack_words[0];
         end
         stack_level = 0;
         held_status = ST_OK;
      end else begin
         // A held error freezes everything until the next finish.
         if (held_status == ST_OK) begin
            case (op)
               OP_PUSH: begin
                  if (!num[NUMBER_WIDTH-1] && num >= PUSH_LIMIT) begin
                     held_status = ST_TOO_LARGE;
                  end else if (stack_level >= OPERAND_SLOTS) begin
                     held_status = ST_OVERFLOW;
                  end else begin
                     stack_words[stack_level] = num;
                     stack_level++;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (stack_level < OPERANDS_NEEDED) begin
                     held_status = ST_UNDERFLOW;
                  end else begin
                     rhs = stack_words[stack_level-1];
                     lhs = stack_words[stack_level-2];
                     stack_level -= OPERANDS_NEEDED;
                     word = '0;
                     case (op)
                        OP_ADD: word = lhs + rhs;
                        OP_SUB: word = lhs - rhs;
                        OP_MUL: word = lhs * rhs;
                        default: begin
                           // Divide on magnitudes, fix the sign afterwards:
                           // truncates toward zero, and MIN / -1 wraps to MIN.
                           mag_l = lhs[VALUE_WIDTH-1] ? -lhs : lhs;
                           mag_r = rhs[VALUE_WIDTH-1] ? -rhs : rhs;
                           if (rhs == '0) begin
                              held_status = ST_DIV_ZERO;
                           end else begin
                              word = mag_l / mag_r;
                              if (lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1]) begin
                                 word = -word;
                              end
                           end
                        end
                     endcase
                     // A zero divisor leaves both operands popped.
                     if (held_status == ST_OK) begin
                        stack_words[stack_level] = word;
                        stack_level++;
                     end
                  end
               end
               default: held_status = ST_BAD_TOKEN;
            endcase
         end
         res.status = held_status;
      end
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Token sequences
   // -------------------------------------------------------------------------
   token_type   pending_tokens [$];
   token_type   draft_tokens [$];
   outcome_type expected_results [$];
   int          queued_tokens = 0;

   function automatic token_type make_token(logic [OPCODE_WIDTH-1:0] op,
                                            logic [NUMBER_WIDTH-1:0] num);
      token_type tok;
      tok.opcode      = op;
      tok.number      = num;
      tok.drain_first = 1'b0;
      return tok;
   endfunction

   function automatic void draft(logic [OPCODE_WIDTH-1:0] op,
                                 logic [NUMBER_WIDTH-1:0] num);
      draft_tokens.push_back(make_token(op, num));
   endfunction

   // Move the drafted sequence to the send queue; optionally hold the sender
   // until every outstanding result has come back before its first token.
   function automatic void commit_draft(bit drain);
      if (drain && draft_tokens.size() != 0) begin
         draft_tokens[0].drain_first = 1'b1;
      end
      queued_tokens += draft_tokens.size();
      while (draft_tokens.size() != 0) begin
         pending_tokens.push_back(draft_tokens.pop_front());
      end
   endfunction

   function automatic logic [NUMBER_WIDTH-1:0] pick_operand();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)      return $urandom_range(0, PUSH_LIMIT - 1);
      else if (r < 75) return 32'd0 - $urandom_range(1, 20);
      else if (r < 90) return $urandom | 32'h8000_0000;
      else if (r < 95) return 32'h8000_0000;
      else             return 32'hFFFF_FFFF;
   endfunction

   function automatic logic [NUMBER_WIDTH-1:0] pick_too_large();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5)       return $urandom_range(PUSH_LIMIT, 99);
      else if (r < 9)  return ($urandom & 32'h7FFF_FFFF) | 32'h0000_0010;
      else             return 32'h7FFF_FFFF;
   endfunction

   function automatic logic [OPCODE_WIDTH-1:0] pick_operator();
      case ($urandom_range(0, 3))
         0:       return OP_ADD;
         1:       return OP_SUB;
         2:       return OP_MUL;
         default: return OP_DIV;
      endcase
   endfunction

   // Draft a well-formed expression that reduces to exactly one value.
   function automatic void draft_expression(int operands);
      int level;
      int left;
      level = 0;
      left  = operands;
      while (left > 0 || level > 1) begin
         if (level >= 2 && (left == 0 || $urandom_range(0, 9) < 4)) begin
            draft(pick_operator(), $urandom);
            level--;
         end else begin
            draft(OP_PUSH, pick_operand());
            level++;
            left--;
         end
      end
   endfunction

   function automatic int pick_operand_count();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
   endfunction

   // -------------------------------------------------------------------------
   // Driver: bursts of transfers with random gaps in between.
   // -------------------------------------------------------------------------
   int        burst_left = 0;
   int        gap_left   = 0;
   int        tokens_sent = 0;
   bit [7:0]  statuses_expected = '0;

   always @(posedge clock) begin
      token_type   tok;
      outcome_type want;
      if (reset) begin
         token_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (token_bus.valid && token_bus.ready) begin
            want = evaluate_token(token_bus.opcode, token_bus.number);
            expected_results.push_back(want);
            statuses_expected[want.status] = 1'b1;
            tokens_sent++;
         end
         // Hold a token that has not been taken yet; otherwise pick what comes next.
         if (!token_bus.valid || token_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               token_bus.valid <= 1'b0;
            end else if (pending_tokens.size() == 0 ||
                         (pending_tokens[0].drain_first && expected_results.size() != 0)) begin
               token_bus.valid <= 1'b0;
            end else begin
               tok = pending_tokens.pop_front();
               token_bus.valid  <= 1'b1;
               token_bus.opcode <= tok.opcode;
               token_bus.number <= tok.number;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 8);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: receiver stalls follow a rotating pattern; every result is
   // checked against the oldest expectation.
   // -------------------------------------------------------------------------
   int unsigned rx_cycle       = 0;
   int          stall_left     = 0;
   int          results_checked = 0;
   int          finishes_seen  = 0;
   int          values_seen    = 0;
   int          failures       = 0;

   function automatic void log_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t ns  MISMATCH  %s", $time, msg);
      end
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         result_bus.ready <= 1'b0;
         rx_cycle   = 0;
         stall_left = 0;
      end else begin
         if (result_bus.valid && result_bus.ready) begin
            if (expected_results.size() == 0) begin
               log_failure($sformatf("unexpected result: status=%0d value=%h done=%b",
                                     result_bus.status, result_bus.value,
                                     result_bus.done_res));
            end else begin
               want = expected_results.pop_front();
               if (result_bus.status !== want.status || result_bus.value !== want.value ||
                   result_bus.done_res !== want.done) begin
                  log_failure($sformatf(
                     {"result %0d: expected status=%0d value=%h done=%b, ",
                      "got status=%0d value=%h done=%b"},
                     results_checked, want.status, want.value, want.done,
                     result_bus.status, result_bus.value, result_bus.done_res));
               end
               if (want.done) finishes_seen++;
               if (want.done && want.status == ST_OK) values_seen++;
            end
            results_checked++;
         end
         // Rotate through four receiver behaviors in turn.
         rx_cycle++;
         case ((rx_cycle / 300) % 4)
            0: result_bus.ready <= 1'b1;
            1: result_bus.ready <= ($urandom_range(0, 2) != 0);
            2: result_bus.ready <= ((rx_cycle % 7) < 3);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  result_bus.ready <= 1'b0;
               end else begin
                  result_bus.ready <= 1'b1;
                  if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 40);
               end
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: count cycles with no transfer on either channel.
   // -------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (token_bus.valid && token_bus.ready) ||
          (result_bus.valid && result_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      int directed_tokens;
      int seq_no;
      int kind;
      int count;

      token_bus.valid  = 1'b0;
      token_bus.opcode = OP_PUSH;
      token_bus.number = '0;
      result_bus.ready = 1'b0;

      // Finish on an empty stack.
      draft(OP_FINISH, 32'h0);
      // Multiply and subtract with extreme small operands.
      draft(OP_PUSH, 32'd9);
      draft(OP_PUSH, 32'hFFFF_FFFF);
      draft(OP_MUL, 32'hFFFF_FFFF);
      draft(OP_PUSH, 32'd0);
      draft(OP_SUB, 32'h0);
      draft(OP_FINISH, 32'h0);
      // Most negative divided by minus one wraps.
      draft(OP_PUSH, 32'h8000_0000);
      draft(OP_PUSH, 32'hFFFF_FFFF);
      draft(OP_DIV, 32'h0);
      draft(OP_FINISH, 32'h0);
      // Division truncates toward zero, then add.
      draft(OP_PUSH, 32'd7);
      draft(OP_PUSH, 32'hFFFF_FFFE);
      draft(OP_DIV, 32'h0);
      draft(OP_PUSH, 32'd1);
      draft(OP_ADD, 32'h0);
      draft(OP_FINISH, 32'h0);
      // Smallest rejected push; the following operator must be ignored.
      draft(OP_PUSH, PUSH_LIMIT);
      draft(OP_ADD, 32'h0);
      draft(OP_FINISH, 32'h0);
      // Operator with a single operand.
      draft(OP_PUSH, 32'd3);
      draft(OP_SUB, 32'h0);
      draft(OP_FINISH, 32'h0);
      // Zero divisor.
      draft(OP_PUSH, 32'd5);
      draft(OP_PUSH, 32'd0);
      draft(OP_DIV, 32'h0);
      draft(OP_FINISH, 32'h0);
      // Bad token, and the unused opcode.
      draft(OP_BAD, 32'hFFFF_FFFF);
      draft(OP_FINISH, 32'h0);
      draft(OP_UNUSED, 32'h0);
      draft(OP_FINISH, 32'h0);
      commit_draft(1'b0);
      directed_tokens = queued_tokens;

      // Random part: mostly well-formed expressions, the rest corrupted
      // expressions, stack fills and raw noise. Every twelfth sequence waits
      // for the result queue to empty first.
      seq_no = 0;
      while (queued_tokens - directed_tokens < RANDOM_TOKENS) begin
         kind = $urandom_range(0, 99);
         if (kind < 3) begin
            // Push close to, up to or past the full stack.
            count = $urandom_range(OPERAND_SLOTS - 4, OPERAND_SLOTS + 3);
            repeat (count) draft(OP_PUSH, pick_operand());
            repeat ($urandom_range(0, 2)) draft(pick_operator(), $urandom);
            draft(OP_FINISH, $urandom);
         end else if (kind < 65) begin
            draft_expression(pick_operand_count());
            draft(OP_FINISH, $urandom);
         end else if (kind < 85) begin
            draft_expression(pick_operand_count());
            case ($urandom_range(0, 5))
               0: draft_tokens.insert($urandom_range(0, draft_tokens.size()),
                                      make_token(OP_BAD, $urandom));
               1: draft_tokens.insert($urandom_range(0, draft_tokens.size()),
                                      make_token(OP_UNUSED, $urandom));
               2: draft_tokens.insert($urandom_range(0, draft_tokens.size()),
                                      make_token(OP_PUSH, pick_too_large()));
               3: draft_tokens.push_front(make_token(pick_operator(), $urandom));
               4: draft(OP_PUSH, pick_operand());
               default: void'(draft_tokens.pop_back());
            endcase
            draft(OP_FINISH, $urandom);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               draft(OPCODE_WIDTH'($urandom_range(0, 7)),
                     $urandom_range(0, 1) ? $urandom : pick_operand());
            end
            if ($urandom_range(0, 9) < 7) draft(OP_FINISH, $urandom);
         end
         commit_draft(seq_no % 12 == 0);
         seq_no++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Let everything drain, then allow time for any stray result.
      while (pending_tokens.size() != 0 || token_bus.valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d tokens (%0d directed, %0d sequences) and checked %0d results.",
               tokens_sent, directed_tokens, seq_no, results_checked);
      $display("Finished %0d expressions, %0d with a value; status codes seen: %b.",
               finishes_seen, values_seen, statuses_expected);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures in total", failures);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
